[rtl/core/keypoint_nms_grid_select_unit_defines.svh]
// assertion macros shared by the block
`ifndef KEYPOINT_NMS_GRID_SELECT_UNIT_DEFINES_SVH
`define KEYPOINT_NMS_GRID_SELECT_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KNGS_ASSERT(lbl, ck, rs, prop) lbl: assert property (@(posedge ck) disable iff (rs) \
  prop) else $error("kngs assertion failed");
`define KNGS_IMPLIES(lbl, a, c) `KNGS_ASSERT(lbl, clk, rst, (a) |-> (c))
`else
`define KNGS_ASSERT(lbl, ck, rs, prop)
`define KNGS_IMPLIES(lbl, a, c)
`endif
`endif

[rtl/core/kngs_pkg.sv]
package kngs_pkg;

  // fixed field widths
  localparam int SC_W      = 16;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 4;
  localparam int CRD_W     = 7;
  // map index width: a 7-bit width times a 7-bit height stays below 2^14
  localparam int IDX_W     = 14;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXP   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINP   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd7;

  typedef struct packed {
    logic signed [SC_W-1:0] score;
    logic                   pixel_valid;
    logic                   end_of_map;
  } px_t;

  typedef struct packed {
    logic [5:0]             row_pos;
    logic [5:0]             col_pos;
    logic signed [SC_W-1:0] point_score;
    logic                   empty_set;
    logic                   final_point;
  } kp_t;

  // clamped configuration seen by the back end
  typedef struct packed {
    logic [5:0]       rad;
    logic [6:0]       w;
    logic [6:0]       h;
    logic [6:0]       maxp;
    logic [6:0]       minp;
    logic [3:0]       rows;
    logic [3:0]       cols;
    logic [6:0]       quota;
    logic [IDX_W-1:0] npix;
  } cfg_t;

  // classified pixel beat handed from front to back
  typedef struct packed {
    logic                   wr;
    logic                   last;
    logic [IDX_W-1:0]       addr;
    logic [IDX_W-1:0]       count;
    logic signed [SC_W-1:0] score;
    logic                   valid;
  } cmd_t;

  // survivor list entry
  typedef struct packed {
    logic [CRD_W-1:0]       y;
    logic [CRD_W-1:0]       x;
    logic signed [SC_W-1:0] score;
  } surv_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_CLR,
    B_QUOTA,
    B_SCAN,
    B_FOUND,
    B_CHK,
    B_APPEND,
    B_GRD,
    B_GLAT,
    B_GDIV,
    B_GCRD,
    B_GUPD,
    B_PRD,
    B_PEV,
    B_TFL,
    B_TEV,
    B_DONE
  } back_state_t;

endpackage

[rtl/core/kngs_ram.sv]
module kngs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/kngs_fifo.sv]
module kngs_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kngs_pkg::cmd_t  din,
  output logic            full,
  input  logic            pop,
  output kngs_pkg::cmd_t  dout,
  output logic            nempty
);

  kngs_pkg::cmd_t ent [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;

  assign full   = (cnt == 2'd2);
  assign nempty = (cnt != 2'd0);
  assign dout   = ent[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

endmodule

[rtl/core/kngs_front.sv]
module kngs_front #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int POINT_CAP     = 64,
  parameter int MAX_GRID      = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [kngs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kngs_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                px_valid,
  output logic                                px_stall,
  input  kngs_pkg::px_t                       px_data,
  input  logic                                q_full,
  output logic                                q_push,
  output kngs_pkg::cmd_t                      q_cmd,
  output kngs_pkg::cfg_t                      cfg
);

  localparam logic [6:0] WMAX = (MAX_WIDTH > 127) ? 7'd127 : 7'(MAX_WIDTH);
  localparam logic [6:0] HMAX = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);
  localparam logic [6:0] KMAX = 7'(POINT_CAP);
  localparam logic [3:0] GMAX = (MAX_GRID > 15) ? 4'd15 : 4'(MAX_GRID);

  localparam int IW = kngs_pkg::IDX_W;

  logic [5:0] suppress_radius;
  logic [6:0] max_points;
  logic [6:0] min_points;
  logic [3:0] grid_rows;
  logic [3:0] grid_cols;
  logic [6:0] per_cell_quota;
  logic [6:0] image_width;
  logic [6:0] image_height;

  logic [IW-1:0] pos;
  logic [IW-1:0] pos_after;
  logic          wr;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      suppress_radius <= 6'd0;
      max_points      <= 7'd64;
      min_points      <= 7'd0;
      grid_rows       <= 4'd1;
      grid_cols       <= 4'd1;
      per_cell_quota  <= 7'd0;
      image_width     <= 7'd64;
      image_height    <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kngs_pkg::CFG_RADIUS: suppress_radius <= cfg_data[5:0];
        kngs_pkg::CFG_MAXP:   max_points      <= cfg_data;
        kngs_pkg::CFG_MINP:   min_points      <= cfg_data;
        kngs_pkg::CFG_ROWS:   grid_rows       <= cfg_data[3:0];
        kngs_pkg::CFG_COLS:   grid_cols       <= cfg_data[3:0];
        kngs_pkg::CFG_QUOTA:  per_cell_quota  <= cfg_data;
        kngs_pkg::CFG_WIDTH:  image_width     <= cfg_data;
        kngs_pkg::CFG_HEIGHT: image_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped view of the registers
  always_comb begin
    cfg.rad   = suppress_radius;
    cfg.w     = (image_width == 7'd0) ? 7'd1 : ((image_width > WMAX) ? WMAX : image_width);
    cfg.h     = (image_height == 7'd0) ? 7'd1 :
                ((image_height > HMAX) ? HMAX : image_height);
    cfg.maxp  = (max_points == 7'd0) ? 7'd1 : ((max_points > KMAX) ? KMAX : max_points);
    cfg.minp  = (min_points > cfg.maxp) ? cfg.maxp : min_points;
    cfg.rows  = (grid_rows == 4'd0) ? 4'd1 : ((grid_rows > GMAX) ? GMAX : grid_rows);
    cfg.cols  = (grid_cols == 4'd0) ? 4'd1 : ((grid_cols > GMAX) ? GMAX : grid_cols);
    cfg.quota = per_cell_quota;
    cfg.npix  = IW'(cfg.w) * IW'(cfg.h);
  end

  // classify the beat: store or drop, and close the map on its last pixel
  always_comb begin
    wr        = (pos < cfg.npix);
    pos_after = wr ? (pos + 1'b1) : ((pos > cfg.npix) ? cfg.npix : pos);
    q_cmd.wr    = wr;
    q_cmd.last  = px_data.end_of_map;
    q_cmd.addr  = pos;
    q_cmd.count = pos_after;
    q_cmd.score = px_data.score;
    q_cmd.valid = px_data.pixel_valid;
  end

  assign px_stall = q_full;
  assign q_push   = px_valid && !q_full;

  // load position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      pos <= px_data.end_of_map ? '0 : pos_after;
    end
  end

endmodule

[rtl/core/kngs_back.sv]
`include "keypoint_nms_grid_select_unit_defines.svh"

module kngs_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_GRID   = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  kngs_pkg::cfg_t  cfg,
  input  logic            q_nempty,
  input  kngs_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            kp_valid,
  input  logic            kp_stall,
  output kngs_pkg::kp_t   kp_data
);

  localparam int WCAP   = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
  localparam int HCAP   = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
  localparam int DEPTH  = WCAP * HCAP;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CDEPTH = MAX_GRID * MAX_GRID;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int IW     = kngs_pkg::IDX_W;
  localparam int SW     = $bits(kngs_pkg::surv_t);

  kngs_pkg::back_state_t state, state_next;

  logic [IW-1:0] map_cnt, map_cnt_next;
  logic [IW-1:0] i_cnt, i_cnt_next;
  logic [IW-1:0] pidx, pidx_next;
  logic [IW-1:0] prev_idx, prev_idx_next;
  logic [IW-1:0] best_idx, best_idx_next;
  logic [IW-1:0] ns, ns_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] k, k_next;
  logic [6:0]    sx, sx_next, sy, sy_next, py, py_next, px, px_next;
  logic [6:0]    best_y, best_y_next, best_x, best_x_next;
  logic          pend, pend_next, jpend, jpend_next;
  logic          found, found_next, have_prev, have_prev_next;
  logic          mode_top, mode_top_next, hit, hit_next, pass2, pass2_next;
  logic          hold_valid, hold_valid_next, kp_valid_next;
  logic signed [15:0] prev_score, prev_score_next, best_score, best_score_next;
  logic [6:0]    quota, quota_next, sel_cnt, sel_cnt_next;
  logic [11:0]   yr, yr_next, xr, xr_next;
  logic [3:0]    cr, cr_next, cc, cc_next;
  logic [CAW-1:0] clr, clr_next;
  kngs_pkg::kp_t hold, hold_next, kp_r, kp_next;

  // memory ports
  logic           sc_we;
  logic [16:0]    sc_wdata, sc_rdata;
  logic           sv_we;
  kngs_pkg::surv_t sv_wdata, sv_rdata;
  logic [AW-1:0]  sv_raddr;
  logic           fl_we, fl_wdata, fl_rdata;
  logic           pk_we, pk_wdata, pk_rdata;
  logic           ce_we;
  logic [CAW-1:0] ce_waddr, ce_addr;
  logic [6:0]     ce_wdata, ce_rdata;

  // helpers
  logic               out_free, add_ok, add, flush;
  kngs_pkg::kp_t      add_data, hold_fin;
  logic signed [15:0] rd_score;
  logic               rd_valid, scan_issue, chk_issue, after_prev;
  logic [6:0]         dy, dx;
  logic [7:0]         cell_full, cells;
  logic               adv_r, adv_c, pick, sel_cond;

  kngs_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_score_ram (
    .clk(clk), .we(sc_we), .waddr(q_cmd.addr[AW-1:0]), .wdata(sc_wdata),
    .raddr(i_cnt[AW-1:0]), .rdata(sc_rdata)
  );

  kngs_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_surv_ram (
    .clk(clk), .we(sv_we), .waddr(ns[AW-1:0]), .wdata(sv_wdata),
    .raddr(sv_raddr), .rdata(sv_rdata)
  );

  kngs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flag_ram (
    .clk(clk), .we(fl_we), .waddr(best_idx[AW-1:0]), .wdata(fl_wdata),
    .raddr(best_idx[AW-1:0]), .rdata(fl_rdata)
  );

  kngs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pick_ram (
    .clk(clk), .we(pk_we), .waddr(k[AW-1:0]), .wdata(pk_wdata),
    .raddr(k[AW-1:0]), .rdata(pk_rdata)
  );

  kngs_ram #(.WIDTH(7), .DEPTH(CDEPTH)) u_cell_ram (
    .clk(clk), .we(ce_we), .waddr(ce_waddr), .wdata(ce_wdata),
    .raddr(ce_addr), .rdata(ce_rdata)
  );

  // datapath helpers
  always_comb begin
    out_free   = !kp_valid || !kp_stall;
    add_ok     = !hold_valid || out_free;
    rd_score   = signed'(sc_rdata[16:1]);
    rd_valid   = sc_rdata[0];
    scan_issue = (state == kngs_pkg::B_SCAN) && (i_cnt < map_cnt);
    chk_issue  = (state == kngs_pkg::B_CHK) && (j < ns);
    after_prev = !have_prev || (rd_score < prev_score) ||
                 ((rd_score == prev_score) && (pidx > prev_idx));
    dy         = (sv_rdata.y > best_y) ? (sv_rdata.y - best_y) : (best_y - sv_rdata.y);
    dx         = (sv_rdata.x > best_x) ? (sv_rdata.x - best_x) : (best_x - sv_rdata.x);
    cell_full  = 8'(cr) * 8'(MAX_GRID) + 8'(cc);
    ce_addr    = cell_full[CAW-1:0];
    cells      = 8'(cfg.rows) * 8'(cfg.cols);
    adv_r      = ((5'(cr) + 5'd1) < 5'(cfg.rows)) &&
                 ((12'(cfg.h) * (12'(cr) + 12'd1)) <= yr);
    adv_c      = ((5'(cc) + 5'd1) < 5'(cfg.cols)) &&
                 ((12'(cfg.w) * (12'(cc) + 12'd1)) <= xr);
    pick       = (ce_rdata < quota);
    sel_cond   = pass2 ? !pk_rdata : pk_rdata;
    sv_raddr   = (state == kngs_pkg::B_CHK) ? j[AW-1:0] : k[AW-1:0];
    hold_fin   = hold;
    hold_fin.final_point = 1'b1;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kngs_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, next values and memory controls
  always_comb begin
    state_next      = state;
    map_cnt_next    = map_cnt;
    i_cnt_next      = i_cnt;
    pidx_next       = pidx;
    prev_idx_next   = prev_idx;
    best_idx_next   = best_idx;
    ns_next         = ns;
    j_next          = j;
    k_next          = k;
    sx_next         = sx;
    sy_next         = sy;
    py_next         = py;
    px_next         = px;
    best_y_next     = best_y;
    best_x_next     = best_x;
    pend_next       = 1'b0;
    jpend_next      = 1'b0;
    found_next      = found;
    have_prev_next  = have_prev;
    mode_top_next   = mode_top;
    hit_next        = hit;
    pass2_next      = pass2;
    prev_score_next = prev_score;
    best_score_next = best_score;
    quota_next      = quota;
    sel_cnt_next    = sel_cnt;
    yr_next         = yr;
    xr_next         = xr;
    cr_next         = cr;
    cc_next         = cc;
    clr_next        = clr;
    q_pop           = 1'b0;
    sc_we           = 1'b0;
    sc_wdata        = {q_cmd.score, q_cmd.valid};
    sv_we           = 1'b0;
    sv_wdata.y      = best_y;
    sv_wdata.x      = best_x;
    sv_wdata.score  = best_score;
    fl_we           = 1'b0;
    fl_wdata        = !hit;
    pk_we           = 1'b0;
    pk_wdata        = pick;
    ce_we           = 1'b0;
    ce_waddr        = ce_addr;
    ce_wdata        = ce_rdata + 7'd1;
    add             = 1'b0;
    add_data        = '0;
    flush           = 1'b0;

    unique case (state)
      // take pixel beats from the queue
      kngs_pkg::B_IDLE: begin
        if (q_nempty) begin
          q_pop = 1'b1;
          sc_we = q_cmd.wr;
          if (q_cmd.last) begin
            map_cnt_next = q_cmd.count;
            ns_next      = '0;
            sel_cnt_next = '0;
            clr_next     = '0;
            state_next   = kngs_pkg::B_CLR;
          end
        end
      end
      // clear per-cell pick counts
      kngs_pkg::B_CLR: begin
        ce_we      = 1'b1;
        ce_waddr   = clr;
        ce_wdata   = 7'd0;
        clr_next   = clr + 1'b1;
        quota_next = 7'd1;
        if (clr == CAW'(CDEPTH - 1)) begin
          state_next = kngs_pkg::B_QUOTA;
        end
      end
      // per-cell quota: the quota register if nonzero, else ceiling division by counting up
      kngs_pkg::B_QUOTA: begin
        if (cfg.quota != 7'd0 || (15'(quota) * 15'(cells)) >= 15'(cfg.maxp)) begin
          if (cfg.quota != 7'd0) begin
            quota_next = cfg.quota;
          end
          mode_top_next  = 1'b0;
          have_prev_next = 1'b0;
          i_cnt_next     = '0;
          sx_next        = '0;
          sy_next        = '0;
          found_next     = 1'b0;
          state_next     = kngs_pkg::B_SCAN;
        end else begin
          quota_next = quota + 7'd1;
        end
      end
      // one pass over the map for the next pixel in score order
      kngs_pkg::B_SCAN: begin
        if (scan_issue) begin
          i_cnt_next = i_cnt + 1'b1;
          pend_next  = 1'b1;
          pidx_next  = i_cnt;
          py_next    = sy;
          px_next    = sx;
          if (sx == cfg.w - 7'd1) begin
            sx_next = '0;
            sy_next = sy + 7'd1;
          end else begin
            sx_next = sx + 7'd1;
          end
        end
        if (pend && rd_valid && after_prev && (!found || rd_score > best_score)) begin
          found_next      = 1'b1;
          best_score_next = rd_score;
          best_idx_next   = pidx;
          best_y_next     = py;
          best_x_next     = px;
        end
        if (!scan_issue && !pend) begin
          state_next = kngs_pkg::B_FOUND;
        end
      end
      kngs_pkg::B_FOUND: begin
        if (found) begin
          if (mode_top) begin
            state_next = kngs_pkg::B_TFL;
          end else begin
            hit_next   = 1'b0;
            j_next     = '0;
            state_next = (cfg.rad == 6'd0) ? kngs_pkg::B_APPEND : kngs_pkg::B_CHK;
          end
        end else if (mode_top) begin
          state_next = kngs_pkg::B_DONE;
        end else begin
          k_next     = '0;
          state_next = kngs_pkg::B_GRD;
        end
      end
      // window test against every survivor so far
      kngs_pkg::B_CHK: begin
        if (chk_issue) begin
          j_next     = j + 1'b1;
          jpend_next = 1'b1;
        end
        if (jpend && (dy <= 7'(cfg.rad)) && (dx <= 7'(cfg.rad))) begin
          hit_next = 1'b1;
        end
        if (!chk_issue && !jpend) begin
          state_next = kngs_pkg::B_APPEND;
        end
      end
      kngs_pkg::B_APPEND: begin
        fl_we = 1'b1;
        if (!hit) begin
          sv_we   = 1'b1;
          ns_next = ns + 1'b1;
        end
        prev_score_next = best_score;
        prev_idx_next   = best_idx;
        have_prev_next  = 1'b1;
        i_cnt_next      = '0;
        sx_next         = '0;
        sy_next         = '0;
        found_next      = 1'b0;
        state_next      = kngs_pkg::B_SCAN;
      end
      // grid balancing over the survivors in order
      kngs_pkg::B_GRD: begin
        if (k == ns) begin
          k_next     = '0;
          pass2_next = 1'b0;
          state_next = kngs_pkg::B_PRD;
        end else begin
          state_next = kngs_pkg::B_GLAT;
        end
      end
      kngs_pkg::B_GLAT: begin
        yr_next    = 12'(sv_rdata.y) * 12'(cfg.rows) + 12'(cfg.rows) - 12'd1;
        xr_next    = 12'(sv_rdata.x) * 12'(cfg.cols) + 12'(cfg.cols) - 12'd1;
        cr_next    = '0;
        cc_next    = '0;
        state_next = kngs_pkg::B_GDIV;
      end
      // find the cell row and column one step a cycle
      kngs_pkg::B_GDIV: begin
        if (adv_r) begin
          cr_next = cr + 4'd1;
        end
        if (adv_c) begin
          cc_next = cc + 4'd1;
        end
        if (!adv_r && !adv_c) begin
          state_next = kngs_pkg::B_GCRD;
        end
      end
      kngs_pkg::B_GCRD: begin
        state_next = kngs_pkg::B_GUPD;
      end
      kngs_pkg::B_GUPD: begin
        pk_we      = 1'b1;
        ce_we      = pick;
        k_next     = k + 1'b1;
        state_next = kngs_pkg::B_GRD;
      end
      // grid picks first, then the other survivors
      kngs_pkg::B_PRD: begin
        if (k == ns || sel_cnt == cfg.maxp) begin
          if (!pass2) begin
            pass2_next = 1'b1;
            k_next     = '0;
          end else if (sel_cnt < cfg.minp) begin
            mode_top_next  = 1'b1;
            have_prev_next = 1'b0;
            i_cnt_next     = '0;
            sx_next        = '0;
            sy_next        = '0;
            found_next     = 1'b0;
            state_next     = kngs_pkg::B_SCAN;
          end else begin
            state_next = kngs_pkg::B_DONE;
          end
        end else begin
          state_next = kngs_pkg::B_PEV;
        end
      end
      kngs_pkg::B_PEV: begin
        add_data.row_pos     = sv_rdata.y[5:0];
        add_data.col_pos     = sv_rdata.x[5:0];
        add_data.point_score = sv_rdata.score;
        if (!sel_cond || add_ok) begin
          add          = sel_cond;
          sel_cnt_next = sel_cnt + (sel_cond ? 7'd1 : 7'd0);
          k_next       = k + 1'b1;
          state_next   = kngs_pkg::B_PRD;
        end
      end
      // top-up from suppressed valid pixels
      kngs_pkg::B_TFL: begin
        state_next = kngs_pkg::B_TEV;
      end
      kngs_pkg::B_TEV: begin
        add_data.row_pos     = best_y[5:0];
        add_data.col_pos     = best_x[5:0];
        add_data.point_score = best_score;
        if (fl_rdata || add_ok) begin
          add             = !fl_rdata;
          sel_cnt_next    = sel_cnt + (fl_rdata ? 7'd0 : 7'd1);
          prev_score_next = best_score;
          prev_idx_next   = best_idx;
          have_prev_next  = 1'b1;
          i_cnt_next      = '0;
          sx_next         = '0;
          sy_next         = '0;
          found_next      = 1'b0;
          state_next      = (sel_cnt_next < cfg.minp) ? kngs_pkg::B_SCAN : kngs_pkg::B_DONE;
        end
      end
      // last result of the map, or the empty marker
      kngs_pkg::B_DONE: begin
        if (out_free) begin
          flush        = 1'b1;
          sel_cnt_next = '0;
          state_next   = kngs_pkg::B_IDLE;
        end
      end
      default: state_next = kngs_pkg::B_IDLE;
    endcase
  end

  // result hold stage and output register
  always_comb begin
    hold_next       = hold;
    hold_valid_next = hold_valid;
    kp_next         = kp_r;
    kp_valid_next   = kp_valid && kp_stall;
    if (add) begin
      if (hold_valid) begin
        kp_next       = hold;
        kp_valid_next = 1'b1;
      end
      hold_next       = add_data;
      hold_valid_next = 1'b1;
    end else if (flush) begin
      if (hold_valid) begin
        kp_next = hold_fin;
      end else begin
        kp_next             = '0;
        kp_next.empty_set   = 1'b1;
        kp_next.final_point = 1'b1;
      end
      kp_valid_next   = 1'b1;
      hold_valid_next = 1'b0;
    end
  end

  assign kp_data = kp_r;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_cnt    <= '0;
      ns         <= '0;
      sel_cnt    <= '0;
      pend       <= 1'b0;
      jpend      <= 1'b0;
      hold_valid <= 1'b0;
      kp_valid   <= 1'b0;
    end else begin
      map_cnt    <= map_cnt_next;
      ns         <= ns_next;
      sel_cnt    <= sel_cnt_next;
      pend       <= pend_next;
      jpend      <= jpend_next;
      hold_valid <= hold_valid_next;
      kp_valid   <= kp_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    i_cnt      <= i_cnt_next;
    pidx       <= pidx_next;
    prev_idx   <= prev_idx_next;
    best_idx   <= best_idx_next;
    j          <= j_next;
    k          <= k_next;
    sx         <= sx_next;
    sy         <= sy_next;
    py         <= py_next;
    px         <= px_next;
    best_y     <= best_y_next;
    best_x     <= best_x_next;
    found      <= found_next;
    have_prev  <= have_prev_next;
    mode_top   <= mode_top_next;
    hit        <= hit_next;
    pass2      <= pass2_next;
    prev_score <= prev_score_next;
    best_score <= best_score_next;
    quota      <= quota_next;
    yr         <= yr_next;
    xr         <= xr_next;
    cr         <= cr_next;
    cc         <= cc_next;
    clr        <= clr_next;
    hold       <= hold_next;
    kp_r       <= kp_next;
  end

  `KNGS_IMPLIES(a_idle_no_hold, state == kngs_pkg::B_IDLE, !hold_valid)
  `KNGS_IMPLIES(a_sel_cap, 1'b1, sel_cnt <= cfg.maxp)
  `KNGS_IMPLIES(a_surv_bound, 1'b1, ns <= map_cnt)
  `KNGS_ASSERT(a_add_room, clk, rst, add |-> add_ok)

endmodule

[rtl/core/keypoint_nms_grid_select_unit.sv]
// Keypoint selection by greedy non-maximum suppression with grid balancing.
// Pixels stream in raster order at one beat per cycle, while the queue is not
// full, into a two-beat queue and are written to the map memory; the queue
// stalls the input once the back end starts on a map. After the end_of_map
// beat the back end clears the per-cell counters, works out the quota, then
// walks the valid pixels in score order: each next pixel costs one full pass
// over the loaded map plus its bookkeeping and, with a nonzero radius, one
// pass over the survivor list. Grid balancing visits each survivor, picking
// walks the survivors in two passes, and each top-up step costs one more map
// pass. Results leave with the grid picks first, then the other survivors,
// then any top-up points, through a one-deep hold and an output register;
// final_point marks the last, and an empty map gives one result with
// empty_set set.
module keypoint_nms_grid_select_unit #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int POINT_CAP     = 64,
  parameter int MAX_GRID      = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kngs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kngs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           px_valid,
  output logic                           px_stall,
  input  kngs_pkg::px_t                  px_data,
  output logic                           kp_valid,
  input  logic                           kp_stall,
  output kngs_pkg::kp_t                  kp_data
);

  kngs_pkg::cfg_t cfg;
  kngs_pkg::cmd_t push_cmd, pop_cmd;
  logic           q_push, q_full, q_pop, q_nempty;

  // front: registers, load position, beat classification
  kngs_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .POINT_CAP(POINT_CAP), .MAX_GRID(MAX_GRID)
  ) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .px_valid(px_valid), .px_stall(px_stall), .px_data(px_data),
    .q_full(q_full), .q_push(q_push), .q_cmd(push_cmd), .cfg(cfg)
  );

  // queue between the two sides
  kngs_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .din(push_cmd), .full(q_full),
    .pop(q_pop), .dout(pop_cmd), .nempty(q_nempty)
  );

  // back: map memory, ordering, suppression, selection
  kngs_back #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_GRID(MAX_GRID)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_nempty(q_nempty), .q_cmd(pop_cmd),
    .q_pop(q_pop), .kp_valid(kp_valid), .kp_stall(kp_stall), .kp_data(kp_data)
  );

endmodule
